@@ hdl/atfe_pkg.sv @@
// Shared types and constants for the accelerometer tilt engine.
// No dependencies; imported by accel_tilt_filter_engine, its checker and the testbench.
package atfe_pkg;

  localparam int TABLE_LEN   = 24;
  localparam int TABLE_IDX_W = $clog2(TABLE_LEN);
  localparam int ANGLE_LIMIT = 11520;
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] CFG_ALPHA     = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [16:0] ALPHA_RESET     = 17'd6554;
  localparam logic [13:0] THRESHOLD_RESET = 14'd1920;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  localparam logic [22:0] ATAN_TABLE [TABLE_LEN] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
    23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
    23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQRT,
    ST_CORDIC,
    ST_ROUND,
    ST_FILTER,
    ST_OUTPUT
  } state_t;

endpackage

@@ hdl/accel_tilt_filter_engine.sv @@
// Tilt angle engine top level: sequencer, shared multiplier, square root and CORDIC.
// Depends on atfe_pkg.
//
// Each sample yields roll = atan2(y, sqrt(x^2+z^2)) and pitch = atan2(-x, sqrt(y^2+z^2))
// in 1/128 degree, smoothed by an exponential filter, plus four threshold flags and a
// sample-timeout fault. One item is in flight at a time and s_axis_tready stays low
// while it works. For a sample, each angle runs two multiplier passes for the sum of
// squares, 20 iterations of the bit-pair square root, CORDIC_STEPS vectoring steps,
// a rounding step and one multiplier pass for the filter, all on one shared datapath.
// A new item can be taken while a finished result still waits in the output register.
// Configuration writes are taken in any cycle outside reset.
module accel_tilt_filter_engine
  import atfe_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // roll_angle[14:0], pitch_angle[29:15], pitch_below[30], pitch_above[31],
  // roll_below[32], roll_above[33], sensor_fault[34], zero[39:35]
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam int SQRT_ITERS = 20;
  localparam int SQRT_W = $clog2(SQRT_ITERS);

  state_t state, state_next;

  logic [16:0] alpha_weight;
  logic [13:0] tilt_threshold;
  logic [15:0] timeout_ticks;

  logic signed [31:0] roll_acc, pitch_acc;
  logic [15:0]        idle_ticks;
  logic               fault_flag;

  logic signed [15:0] ax, ay, az;
  logic               pass;  // 0 roll, 1 pitch
  logic signed [16:0] num_op;
  logic signed [15:0] a_op, b_op;

  logic [31:0]        sq;
  logic [39:0]        rad;
  logic [20:0]        rem;
  logic [19:0]        root;
  logic [SQRT_W-1:0]  sqrt_cnt;

  logic signed [22:0] cx, cy;
  logic signed [23:0] cz;
  logic [STEP_W-1:0]  step;
  logic signed [14:0] angle;

  logic        out_valid;
  logic [39:0] out_data;

  // sequencer outputs
  logic accept;
  logic load_out;

  assign cfg_ready     = !rst;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // ---------------- shared multiplier
  logic signed [17:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [51:0] prod;
  logic signed [51:0] prod_sh;
  logic [16:0]        alpha_eff;
  logic signed [31:0] acc_sel;
  logic signed [32:0] diff;

  assign alpha_eff = (alpha_weight > ALPHA_ONE) ? ALPHA_ONE : alpha_weight;
  assign acc_sel   = pass ? pitch_acc : roll_acc;
  assign diff      = $signed({angle[14], angle, 16'd0}) - 33'(acc_sel);

  always_comb begin
    case (state)
      ST_SQ_A: begin
        mul_a = 18'(a_op);
        mul_b = 34'(a_op);
      end
      ST_SQ_B: begin
        mul_a = 18'(b_op);
        mul_b = 34'(b_op);
      end
      default: begin
        mul_a = $signed({1'b0, alpha_eff});
        mul_b = 34'(diff);
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> 16;

  // ---------------- square root iteration
  logic [22:0] rem_cat, trial;
  logic        sqrt_take;
  assign rem_cat   = {rem, rad[39:38]};
  assign trial     = {1'b0, root, 2'b01};
  assign sqrt_take = rem_cat >= trial;

  // ---------------- CORDIC step
  logic signed [22:0] xs, ys;
  logic signed [23:0] atan_i;
  assign xs     = cx >>> step;
  assign ys     = cy >>> step;
  assign atan_i = $signed({1'b0, ATAN_TABLE[TABLE_IDX_W'(step)]});

  // ---------------- rounding and clamp
  logic signed [24:0] z_bias;
  logic signed [15:0] z_round;
  logic signed [14:0] z_clamp;
  assign z_bias  = 25'(cz) + 25'sd256;
  assign z_round = 16'(z_bias >>> 9);
  always_comb begin
    if (z_round > 16'(ANGLE_LIMIT)) begin
      z_clamp = 15'(ANGLE_LIMIT);
    end else if (z_round < -16'(ANGLE_LIMIT)) begin
      z_clamp = -15'(ANGLE_LIMIT);
    end else begin
      z_clamp = 15'(z_round);
    end
  end

  // ---------------- result word
  logic signed [32:0] thr_pos, thr_neg, roll33, pitch33;
  logic [32:0]        roll_rnd, pitch_rnd;
  assign thr_pos   = $signed({3'd0, tilt_threshold, 16'd0});
  assign thr_neg   = -thr_pos;
  assign roll33    = 33'(roll_acc);
  assign pitch33   = 33'(pitch_acc);
  assign roll_rnd  = roll33 + 33'sd32768;
  assign pitch_rnd = pitch33 + 33'sd32768;

  // ---------------- next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == OP_TICK) ? ST_OUTPUT : ST_SQ_A;
        end
      end
      ST_SQ_A:   state_next = ST_SQ_B;
      ST_SQ_B:   state_next = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_cnt == SQRT_W'(SQRT_ITERS - 1)) state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_ROUND;
      end
      ST_ROUND:  state_next = ST_FILTER;
      ST_FILTER: state_next = pass ? ST_OUTPUT : ST_SQ_A;
      ST_OUTPUT: begin
        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------- sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE:   s_axis_tready = !rst;
      ST_OUTPUT: load_out = !out_valid || m_axis_tready;
      default: begin
        s_axis_tready = 1'b0;
        load_out      = 1'b0;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_weight   <= ALPHA_RESET;
      tilt_threshold <= THRESHOLD_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALPHA:     alpha_weight   <= cfg_data;
        CFG_THRESHOLD: tilt_threshold <= cfg_data[13:0];
        CFG_TIMEOUT:   timeout_ticks  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // filter state, timeout and output register
  logic [16:0] ticks_inc;
  assign ticks_inc = {1'b0, idle_ticks} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_acc   <= '0;
      pitch_acc  <= '0;
      idle_ticks <= '0;
      fault_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        if (s_axis_tuser == OP_TICK) begin
          if (ticks_inc > {1'b0, timeout_ticks}) fault_flag <= 1'b1;
          idle_ticks <= ticks_inc[16] ? 16'hFFFF : ticks_inc[15:0];
        end else begin
          idle_ticks <= '0;
          fault_flag <= 1'b0;
        end
      end
      if (state == ST_FILTER) begin
        if (pass) pitch_acc <= pitch_acc + prod_sh[31:0];
        else      roll_acc  <= roll_acc + prod_sh[31:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= {5'd0, fault_flag, roll33 > thr_pos, roll33 < thr_neg,
                   pitch33 > thr_pos, pitch33 < thr_neg,
                   pitch_rnd[30:16], roll_rnd[30:16]};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        ax     <= s_axis_tdata[15:0];
        ay     <= s_axis_tdata[31:16];
        az     <= s_axis_tdata[47:32];
        pass   <= 1'b0;
        num_op <= 17'($signed(s_axis_tdata[31:16]));
        a_op   <= s_axis_tdata[15:0];
        b_op   <= s_axis_tdata[47:32];
      end
      ST_SQ_A: sq <= prod[31:0];
      ST_SQ_B: begin
        rad      <= {sq + prod[31:0], 8'd0};
        rem      <= '0;
        root     <= '0;
        sqrt_cnt <= '0;
      end
      ST_SQRT: begin
        rad      <= {rad[37:0], 2'b00};
        sqrt_cnt <= sqrt_cnt + SQRT_W'(1);
        if (sqrt_take) begin
          rem  <= 21'(rem_cat - trial);
          root <= {root[18:0], 1'b1};
        end else begin
          rem  <= rem_cat[20:0];
          root <= {root[18:0], 1'b0};
        end
        if (sqrt_cnt == SQRT_W'(SQRT_ITERS - 1)) begin
          // last bit pair: seed the CORDIC with the finished root
          cx   <= $signed({3'b000, root[18:0], sqrt_take});
          cy   <= 23'($signed({num_op, 4'd0}));
          cz   <= '0;
          step <= '0;
        end
      end
      ST_CORDIC: begin
        step <= step + STEP_W'(1);
        if (cy > 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_i;
        end else if (cy < 0) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_i;
        end
      end
      ST_ROUND: angle <= z_clamp;
      ST_FILTER: begin
        pass   <= 1'b1;
        num_op <= -17'(ax);
        a_op   <= ay;
        b_op   <= az;
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/atfe_checker.sv @@
// Port-level checks for accel_tilt_filter_engine, attached by bind below.
// Depends on atfe_pkg for the angle limit.
module atfe_checker
  import atfe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item at a time: after a transfer the input side closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[14:0]) <= 15'(ANGLE_LIMIT))
                   && ($signed(m_axis_tdata[14:0]) >= -15'(ANGLE_LIMIT)))
    else $error("roll out of range");

  // a filtered angle cannot be both above and below the threshold
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[30] && m_axis_tdata[31])
                   && !(m_axis_tdata[32] && m_axis_tdata[33]))
    else $error("above and below flags both set");

endmodule

bind accel_tilt_filter_engine atfe_checker u_atfe_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/accel_tilt_filter_engine_tb.sv @@
// Self-checking testbench for accel_tilt_filter_engine: tilt angles, filter, flags, timeout.
// Depends on atfe_pkg and the accel_tilt_filter_engine RTL; carries its own bit-exact predictor.
// Directed checks first, then randomized traffic with sender gaps and receiver stalls.
module accel_tilt_filter_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atfe_pkg::*;

  localparam int CORDIC_STEPS   = 16;
  localparam int SAMPLE_LATENCY = 2 * (24 + CORDIC_STEPS) + 2;
  localparam int DRAIN_CYCLES   = SAMPLE_LATENCY + 8;
  localparam int CYCLE_LIMIT    = 500_000;
  localparam int MAX_REPORTS    = 40;
  // no register behind this index
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [4:0]  pad;
    logic        sensor_fault;
    logic        roll_above;
    logic        roll_below;
    logic        pitch_above;
    logic        pitch_below;
    logic [14:0] pitch_angle;
    logic [14:0] roll_angle;
  } tilt_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // accel_x[15:0], accel_y[31:16], accel_z[47:32]
  logic        s_axis_tuser = OP_SAMPLE;  // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // roll_angle[14:0], pitch_angle[29:15], pitch_below[30], pitch_above[31],
  // roll_below[32], roll_above[33], sensor_fault[34], zero[39:35]
  logic [39:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_data = '0;

  accel_tilt_filter_engine #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor copy of registers and state
  logic [16:0]  alpha_reg     = ALPHA_RESET;
  logic [13:0]  thr_reg       = THRESHOLD_RESET;
  logic [15:0]  timeout_reg   = TIMEOUT_RESET;
  int           roll_acc      = 0;
  int           pitch_acc     = 0;
  logic [15:0]  idle_ticks    = '0;
  logic         fault_flag    = 1'b0;

  tilt_result_t pending_results[$];
  tilt_result_t got_result;
  tilt_result_t want_result;
  int           mismatches    = 0;
  int           result_count  = 0;
  int           cycle_count   = 0;
  bit           tx_idle_en    = 1'b0;
  int           burst_left    = 0;
  logic         rx_stall_en   = 1'b0;
  int           rx_hold       = 0;

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res;
    longint unsigned probe;
    res = 0;
    probe = 64'd1 << 62;
    while (probe > s) probe >>= 2;
    while (probe != 0) begin
      if (s >= res + probe) begin
        s -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // atan2(num, sqrt(a^2 + b^2)) in 1/128 degree
  function automatic longint tilt_angle128(input longint num, input longint a, input longint b);
    longint unsigned sq;
    longint x, y, z, xs, ys;
    int steps;
    sq = a * a + b * b;
    x = longint'(int_sqrt(sq << 8));
    y = num * 16;
    z = 0;
    steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(ATAN_TABLE[i]);
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(ATAN_TABLE[i]);
      end
    end
    z = (z + 256) >>> 9;
    if (z > ANGLE_LIMIT) z = ANGLE_LIMIT;
    if (z < -ANGLE_LIMIT) z = -ANGLE_LIMIT;
    return z;
  endfunction

  function automatic int filter_step(input int acc, input longint angle);
    longint a, d;
    a = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    d = angle * 65536 - acc;
    return int'(acc + ((a * d) >>> 16));
  endfunction

  task automatic predict_result(input logic op, input logic signed [15:0] ax,
                                input logic signed [15:0] ay, input logic signed [15:0] az);
    tilt_result_t r;
    longint thr;
    logic [16:0] next;
    if (op == OP_SAMPLE) begin
      roll_acc = filter_step(roll_acc, tilt_angle128(ay, ax, az));
      pitch_acc = filter_step(pitch_acc, tilt_angle128(-longint'(ax), ay, az));
      idle_ticks = '0;
      fault_flag = 1'b0;
    end else begin
      // compare before saturating, so the 65536th tick still trips a 65535 limit
      next = {1'b0, idle_ticks} + 17'd1;
      if (next > {1'b0, timeout_reg}) fault_flag = 1'b1;
      idle_ticks = next[16] ? 16'hFFFF : next[15:0];
    end
    thr = longint'(thr_reg) * 65536;
    r.pad = '0;
    r.roll_angle = 15'((longint'(roll_acc) + 32768) >>> 16);
    r.pitch_angle = 15'((longint'(pitch_acc) + 32768) >>> 16);
    r.pitch_below = (longint'(pitch_acc) < -thr);
    r.pitch_above = (longint'(pitch_acc) > thr);
    r.roll_below = (longint'(roll_acc) < -thr);
    r.roll_above = (longint'(roll_acc) > thr);
    r.sensor_fault = fault_flag;
    pending_results.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    // keep the log short when the design is badly off
    if (mismatches <= MAX_REPORTS)
      $display("result %0d: %s got %0d expected %0d", result_count, field, got, want);
  endtask

  task automatic send_item(input logic op, input logic [15:0] ax, input logic [15:0] ay,
                           input logic [15:0] az);
    int gap;
    if (tx_idle_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {az, ay, ax};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_result(op, ax, ay, az);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALPHA:     alpha_reg = value;
      CFG_THRESHOLD: thr_reg = value[13:0];
      CFG_TIMEOUT:   timeout_reg = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [16:0] alpha, input logic [13:0] thr,
                                input logic [15:0] tmo);
    write_reg(CFG_ALPHA, alpha);
    write_reg(CFG_THRESHOLD, {3'b0, thr});
    write_reg(CFG_TIMEOUT, {1'b0, tmo});
  endtask

  task automatic send_random_sample();
    logic [15:0] v[3];
    int kind;
    int dom;
    int t;
    kind = $urandom_range(0, 9);
    dom = $urandom_range(0, 2);
    for (int k = 0; k < 3; k++) begin
      if (kind < 5) begin
        // gravity mostly along one axis, some tilt on the others
        if (k == dom) begin
          t = $urandom_range(14000, 19000);
          v[k] = $urandom_range(0, 1) ? 16'(t) : 16'(-t);
        end else begin
          t = $urandom_range(0, 16000);
          v[k] = 16'(t - 8000);
        end
      end else if (kind < 8) begin
        v[k] = 16'($urandom);
      end else begin
        case ($urandom_range(0, 3))
          0: v[k] = 16'h8000;
          1: v[k] = 16'h7FFF;
          2: v[k] = 16'h0000;
          default: v[k] = 16'($urandom_range(0, 6)) - 16'd3;
        endcase
      end
    end
    send_item(OP_SAMPLE, v[0], v[1], v[2]);
  endtask

  // receiver: ready and stalled stretches of random length
  always @(posedge clk) begin
    if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
      rx_hold <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rx_hold <= ($urandom_range(0, 15) == 0) ? 20 : $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1'b1;
      rx_hold <= $urandom_range(0, 9);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result = m_axis_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, tdata", got_result, 0);
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.roll_angle !== want_result.roll_angle)
          report_mismatch("roll_angle", $signed(got_result.roll_angle),
                          $signed(want_result.roll_angle));
        if (got_result.pitch_angle !== want_result.pitch_angle)
          report_mismatch("pitch_angle", $signed(got_result.pitch_angle),
                          $signed(want_result.pitch_angle));
        if (got_result.pitch_below !== want_result.pitch_below)
          report_mismatch("pitch_below", got_result.pitch_below, want_result.pitch_below);
        if (got_result.pitch_above !== want_result.pitch_above)
          report_mismatch("pitch_above", got_result.pitch_above, want_result.pitch_above);
        if (got_result.roll_below !== want_result.roll_below)
          report_mismatch("roll_below", got_result.roll_below, want_result.roll_below);
        if (got_result.roll_above !== want_result.roll_above)
          report_mismatch("roll_above", got_result.roll_above, want_result.roll_above);
        if (got_result.sensor_fault !== want_result.sensor_fault)
          report_mismatch("sensor_fault", got_result.sensor_fault, want_result.sensor_fault);
        if (got_result.pad !== want_result.pad)
          report_mismatch("pad bits", got_result.pad, want_result.pad);
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** accel_tilt_filter_engine: FAILED **");
      $finish;
    end
  end

  // reset register values; axis extremes, zero vector, both item kinds
  task automatic test_reset_defaults();
    tx_idle_en = 1'b0;
    rx_stall_en <= 1'b0;
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h4000);
    send_item(OP_SAMPLE, 16'h4000, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'hC000, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0000, 16'h4000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0000, 16'hC000, 16'hC000);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(OP_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_SAMPLE, 16'h8000, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h7FFF, 16'h8000, 16'h0000);
    send_item(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_results_drained();
  endtask

  task automatic test_register_extremes();
    tx_idle_en = 1'b0;
    rx_stall_en <= 1'b0;
    // full weight, zero threshold, one tick allowed
    write_settings(ALPHA_ONE, 14'd0, 16'd1);
    send_item(OP_SAMPLE, 16'h0000, 16'h4000, 16'h0000);
    send_item(OP_SAMPLE, 16'h4000, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h4000);
    wait_results_drained();
    // alpha past one acts as one; threshold at the angle limit never trips at 90 deg
    write_reg(CFG_ALPHA, 17'h1FFFF);
    write_reg(CFG_THRESHOLD, 17'(ANGLE_LIMIT));
    send_item(OP_SAMPLE, 16'h0000, 16'hC000, 16'h0000);
    wait_results_drained();
    write_reg(CFG_UNUSED, 17'($urandom));
    send_item(OP_SAMPLE, 16'h0000, 16'h7FFF, 16'h0000);
    wait_results_drained();
    // frozen filter, widest threshold, zero timeout
    write_settings(17'd0, 14'h3FFF, 16'd0);
    send_item(OP_SAMPLE, 16'h1234, 16'h8000, 16'h0F00);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    wait_results_drained();
    write_settings(17'd1, 14'd100, 16'hFFFF);
    send_item(OP_SAMPLE, 16'h4000, 16'h4000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
    wait_results_drained();
  endtask

  // fault trips on the tick that passes the limit and clears with the next sample
  task automatic test_timeout_limit();
    tx_idle_en = 1'b0;
    rx_stall_en <= 1'b0;
    write_reg(CFG_TIMEOUT, 17'd4);
    send_item(OP_SAMPLE, 16'h0100, 16'h0200, 16'h4000);
    repeat (6) send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    send_item(OP_SAMPLE, 16'h0100, 16'h0200, 16'h4000);
    send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
    wait_results_drained();
  endtask

  task automatic run_traffic_phase(input logic [16:0] alpha, input logic [13:0] thr,
                                   input logic [15:0] tmo, input int n_items, input bit idle);
    int sent;
    int run;
    int reach;
    write_settings(alpha, thr, tmo);
    tx_idle_en = idle;
    rx_stall_en <= idle;
    burst_left = 0;
    sent = 0;
    reach = (tmo < 6) ? int'(tmo) : 6;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        // tick runs around the timeout so the fault sets and clears
        run = $urandom_range(1, reach + 3);
        repeat (run) send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom));
        sent += run;
      end else begin
        send_random_sample();
        sent++;
      end
    end
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(ALPHA_ONE, 14'($urandom_range(0, 2000)), 16'($urandom_range(1, 4)),
                      50, 1'b0);
    run_traffic_phase(17'd1, 14'd0, 16'd1, 50, 1'b1);
    run_traffic_phase(17'h1FFFF, 14'(ANGLE_LIMIT), 16'd3, 50, 1'b1);
    run_traffic_phase(17'($urandom_range(1, 65536)), 14'($urandom_range(0, ANGLE_LIMIT)),
                      16'($urandom_range(1, 8)), 50, 1'b1);
    run_traffic_phase(17'($urandom), 14'($urandom), 16'($urandom_range(0, 10)), 50, 1'b1);
    run_traffic_phase(17'($urandom_range(30000, 65536)), 14'($urandom_range(0, 3000)),
                      16'($urandom_range(2, 6)), 50, 1'b1);
    run_traffic_phase(17'd0, 14'($urandom_range(0, 500)), 16'd2, 25, 1'b1);
    run_traffic_phase(17'd65535, 14'h3FFF, 16'hFFFF, 50, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_timeout_limit();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("** accel_tilt_filter_engine: PASSED **");
    end else begin
      $display("** accel_tilt_filter_engine: FAILED **");
    end
    $finish;
  end

endmodule
